// File: rtl/core/pli_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ---------------------------------------------------------------------------
package pli_pkg;

    localparam int DEFAULT_MAX_POINTS = 64;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_EVAL   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FEW      = 2'd2;
    localparam logic [1:0] ST_ZERO_DX  = 2'd3;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = -32'sh8000_0000;

    // request to the multiply/divide unit
    typedef struct packed {
        logic        start;
        logic [32:0] mul_a;
        logic [32:0] mul_b;
        logic [31:0] divisor;
    } md_req_t;

    // response from the multiply/divide unit
    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic        ovf;
    } md_rsp_t;

endpackage

// File: rtl/core/pli_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_in_if / pli_out_if
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface pli_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;

    modport source (output valid, kind, x_value, y_value, input ready);
    modport sink   (input valid, kind, x_value, y_value, output ready);
endinterface

interface pli_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [5:0]         segment;
    logic [1:0]         status;

    modport source (output valid, result_value, segment, status, input ready);
    modport sink   (input valid, result_value, segment, status, output ready);
endinterface

// File: rtl/core/pli_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_ram
// Generic RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/core/pli_muldiv.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_muldiv
// Shift-add multiply then restoring divide on one shared 34-bit adder.
// ---------------------------------------------------------------------------
module pli_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  pli_pkg::md_req_t req,
    output pli_pkg::md_rsp_t rsp
);
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_MUL  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;
    localparam logic [6:0] MUL_STEPS = 7'd33;
    localparam logic [6:0] DIV_STEPS = 7'd66;

    logic [1:0]  phase_reg, phase_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [65:0] acc_reg, acc_next;
    logic [32:0] a_reg, a_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quot_reg, quot_next;
    logic        ovf_reg, ovf_next;
    logic        done_reg, done_next;

    logic [32:0] rem_sh;
    logic [33:0] op_a, op_b, sum;
    logic        cin;

    assign rem_sh = {rem_reg, acc_reg[65]};

    // shared adder: add partial product, or trial-subtract divisor
    always_comb
    begin
        if (phase_reg == PH_DIV)
        begin
            op_a = {1'b0, rem_sh};
            op_b = ~{2'b00, d_reg};
            cin  = 1'b1;
        end
        else
        begin
            op_a = {1'b0, acc_reg[65:33]};
            op_b = acc_reg[0] ? {1'b0, a_reg} : 34'd0;
            cin  = 1'b0;
        end
        sum = op_a + op_b + {33'd0, cin};
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        d_next     = d_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = {33'd0, req.mul_b};
                    a_next     = req.mul_a;
                    d_next     = req.divisor;
                    cnt_next   = 7'd0;
                    phase_next = PH_MUL;
                end
            end
            PH_MUL:
            begin
                acc_next = {sum, acc_reg[32:1]};
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == MUL_STEPS - 7'd1)
                begin
                    cnt_next   = 7'd0;
                    rem_next   = 32'd0;
                    quot_next  = 32'd0;
                    ovf_next   = 1'b0;
                    phase_next = PH_DIV;
                end
            end
            PH_DIV:
            begin
                acc_next  = {acc_reg[64:0], 1'b0};
                rem_next  = sum[33] ? rem_sh[31:0] : sum[31:0];
                quot_next = {quot_reg[30:0], ~sum[33]};
                ovf_next  = ovf_reg | quot_reg[31];
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == DIV_STEPS - 7'd1)
                begin
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        acc_reg  <= acc_next;
        a_reg    <= a_next;
        d_reg    <= d_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.ovf  = ovf_reg;
endmodule

// File: rtl/core/piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator
// Sorted breakpoint table with insert, clear and interpolated evaluation.
// ---------------------------------------------------------------------------
//  channel | dir | payload                          | transaction
//  req     | in  | kind, x_value, y_value           | valid & ready
//  rsp     | out | result_value, segment, status    | valid & ready
//
//  Clear, unused kinds, full-table inserts and short-table evaluations go
//  straight from idle to the finish state. Insert: each larger point is read
//  and then shifted up one slot, a pace set by the single read port of the
//  breakpoint RAM. Evaluate: an upper-bound search, a fetch and a handoff,
//  then a multiply and a divide in the shared multiply/divide adder.
//  Reset clears the point count and control; table contents stay undefined.
//  req.ready is high only while the sequencer is idle; a result held in the
//  output register does not stall the next transaction until it is finished.
// ---------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int MAX_POINTS = pli_pkg::DEFAULT_MAX_POINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    pli_in_if.sink      req,
    pli_out_if.source   rsp
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
    localparam logic [CW-1:0] ONE     = CW'(1);
    localparam logic [CW-1:0] TWO     = CW'(2);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INS_CHK  = 4'd1;
    localparam logic [3:0] S_INS_CMP  = 4'd2;
    localparam logic [3:0] S_SRCH_CHK = 4'd3;
    localparam logic [3:0] S_SRCH_CMP = 4'd4;
    localparam logic [3:0] S_SEG_RD0  = 4'd5;
    localparam logic [3:0] S_SEG_RD1  = 4'd6;
    localparam logic [3:0] S_SEG_GOT  = 4'd7;
    localparam logic [3:0] S_MD_WAIT  = 4'd8;
    localparam logic [3:0] S_FIN      = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] seg_reg, seg_next;
    logic [1:0]  kind_reg, kind_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] x0_reg, x0_next;
    logic signed [31:0] y0_reg, y0_next;
    logic        neg_reg, neg_next;
    logic signed [31:0] res_reg, res_next;
    logic [1:0]  st_reg, st_next;

    logic               out_valid_reg;
    logic signed [31:0] out_res_reg;
    logic [5:0]         out_seg_reg;
    logic [1:0]         out_st_reg;

    // table RAM: {x, y}
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;
    logic signed [31:0] rd_x, rd_y;

    pli_pkg::md_req_t md_req;
    pli_pkg::md_rsp_t md_rsp;

    logic [CW-1:0] seg_pick, seg_cap;
    logic signed [32:0] dx, dy, dq;
    logic [32:0]   mag_dy, mag_dq;
    logic signed [33:0] sum_r;
    logic          fin_go;

    pli_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pli_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    assign rd_x = rdata[63:32];
    assign rd_y = rdata[31:0];

    // segment chosen from the upper-bound search, clamped to the last segment
    assign seg_cap  = count_reg - TWO;
    always_comb
    begin
        seg_pick = (lo_reg == '0) ? '0 : lo_reg - ONE;
        if (seg_pick > seg_cap)
        begin
            seg_pick = seg_cap;
        end
    end

    // segment deltas, valid while the right breakpoint sits on the read port
    assign dx = 33'(rd_x) - 33'(x0_reg);
    assign dy = 33'(rd_y) - 33'(y0_reg);
    assign dq = 33'(x_reg) - 33'(x0_reg);
    assign mag_dy = dy[32] ? 33'(-dy) : 33'(dy);
    assign mag_dq = dq[32] ? 33'(-dq) : 33'(dq);

    // apply the quotient with its sign
    assign sum_r = neg_reg ? 34'(y0_reg) - 34'($signed({2'b00, md_rsp.quot}))
                           : 34'(y0_reg) + 34'($signed({2'b00, md_rsp.quot}));

    assign req.ready = (state_reg == S_IDLE);
    assign fin_go    = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        seg_next   = seg_reg;
        kind_next  = kind_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        x0_next    = x0_reg;
        y0_next    = y0_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        we         = 1'b0;
        waddr      = pos_reg[AW-1:0];
        wdata      = {x_reg, y_reg};
        raddr      = '0;
        md_req     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next = req.kind;
                    x_next    = req.x_value;
                    y_next    = req.y_value;
                    res_next  = '0;
                    seg_next  = '0;
                    st_next   = pli_pkg::ST_OK;
                    pos_next  = count_reg;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    state_next = S_FIN;
                    case (req.kind)
                        pli_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        pli_pkg::KIND_INSERT:
                        begin
                            if (count_reg >= CNT_MAX)
                            begin
                                st_next = pli_pkg::ST_FULL;
                            end
                            else
                            begin
                                state_next = S_INS_CHK;
                            end
                        end
                        pli_pkg::KIND_EVAL:
                        begin
                            if (count_reg < TWO)
                            begin
                                st_next = pli_pkg::ST_FEW;
                            end
                            else
                            begin
                                state_next = S_SRCH_CHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_INS_CHK:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    seg_next   = pos_reg;
                    count_next = count_reg + ONE;
                    state_next = S_FIN;
                end
                else
                begin
                    raddr      = AW'(pos_reg - ONE);
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                we = 1'b1;
                if (rd_x > x_reg)
                begin
                    // shift the larger neighbor up one slot
                    wdata      = rdata;
                    pos_next   = pos_reg - ONE;
                    state_next = S_INS_CHK;
                end
                else
                begin
                    seg_next   = pos_reg;
                    count_next = count_reg + ONE;
                    state_next = S_FIN;
                end
            end
            S_SRCH_CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = lo_reg + ((hi_reg - lo_reg) >> 1);
                    raddr      = AW'(lo_reg + ((hi_reg - lo_reg) >> 1));
                    state_next = S_SRCH_CMP;
                end
                else
                begin
                    seg_next   = seg_pick;
                    raddr      = AW'(seg_pick);
                    state_next = S_SEG_RD0;
                end
            end
            S_SRCH_CMP:
            begin
                if (rd_x <= x_reg)
                begin
                    lo_next = mid_reg + ONE;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH_CHK;
            end
            S_SEG_RD0:
            begin
                // left breakpoint is on the read port; fetch the right one
                x0_next    = rd_x;
                y0_next    = rd_y;
                raddr      = AW'(seg_reg + ONE);
                state_next = S_SEG_RD1;
            end
            S_SEG_RD1:
            begin
                // hold the right breakpoint on the read port
                raddr      = AW'(seg_reg + ONE);
                state_next = S_SEG_GOT;
            end
            S_SEG_GOT:
            begin
                if (dx <= 33'sd0)
                begin
                    res_next   = y0_reg;
                    st_next    = pli_pkg::ST_ZERO_DX;
                    state_next = S_FIN;
                end
                else
                begin
                    neg_next       = dy[32] != dq[32];
                    md_req.start   = 1'b1;
                    md_req.mul_a   = mag_dy;
                    md_req.mul_b   = mag_dq;
                    md_req.divisor = dx[31:0];
                    state_next     = S_MD_WAIT;
                end
            end
            S_MD_WAIT:
            begin
                if (md_rsp.done)
                begin
                    if (md_rsp.ovf)
                    begin
                        res_next = neg_reg ? pli_pkg::Q_MIN : pli_pkg::Q_MAX;
                    end
                    else if (sum_r > 34'(pli_pkg::Q_MAX))
                    begin
                        res_next = pli_pkg::Q_MAX;
                    end
                    else if (sum_r < 34'(pli_pkg::Q_MIN))
                    begin
                        res_next = pli_pkg::Q_MIN;
                    end
                    else
                    begin
                        res_next = sum_r[31:0];
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_FIN && fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        mid_reg  <= mid_next;
        seg_reg  <= seg_next;
        kind_reg <= kind_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        neg_reg  <= neg_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        if (state_reg == S_FIN && fin_go)
        begin
            // kind is only needed for the result; every kind but evaluate answers zero
            out_res_reg <= (kind_reg == pli_pkg::KIND_EVAL) ? res_reg : '0;
            out_seg_reg <= 6'(seg_reg);
            out_st_reg  <= st_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.result_value = out_res_reg;
    assign rsp.segment      = out_seg_reg;
    assign rsp.status       = out_st_reg;
endmodule

// File: rtl/core/pli_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pli_checker
// Port-level checks of the interpolator, bound to the top level.
// ---------------------------------------------------------------------------
module pli_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result_value,
    input logic [5:0]  segment,
    input logic [1:0]  status
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(segment) && $stable(status))
        else $error("stalled result changed");

    // the sequencer is busy after taking a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accept");

    a_few: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pli_pkg::ST_FEW |-> result_value == 32'd0
            && segment == 6'd0)
        else $error("short table result not zero");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == pli_pkg::ST_FULL |-> result_value == 32'd0
            && segment == 6'd0)
        else $error("full table result not zero");
endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .result_value (rsp.result_value),
    .segment      (rsp.segment),
    .status       (rsp.status)
);
